FILE: hw/rtl/wlsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlsf_pkg: shared constants and types of the windowed least-squares fit
// Field widths, accumulator widths and the datapath width of the shared
// add/subtract unit that does the window-end multiplies and divides.
// ----------------------------------------------------------------------------
package wlsf_pkg;

	// sample limit for a window length of zero
	localparam int MAX_SAMPLES = 4096;

	// field widths
	localparam int YEAR_W  = 12;
	localparam int Y_W     = 16;
	localparam int WLEN_W  = 8;
	localparam int SLOPE_W = 32;
	localparam int ICPT_W  = 40;
	localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);

	// fraction bits of the anomaly, added to the slope numerator
	localparam int Y_FRAC = 12;

	// window length after reset
	localparam int WLEN_RESET = 10;

	// accumulator widths
	localparam int SDX_W  = CNT_W + YEAR_W;
	localparam int SY_W   = CNT_W + Y_W;
	localparam int SDXX_W = CNT_W + 2 * YEAR_W;
	localparam int SDXY_W = CNT_W + YEAR_W + Y_W + 1;

	// per-sample products
	localparam int PDXX_W = 2 * YEAR_W;
	localparam int PDXY_W = YEAR_W + Y_W + 1;

	// window-end values
	localparam int DEN_W = 2 * CNT_W + 2 * YEAR_W;
	localparam int DXY_W = 2 * CNT_W + YEAR_W + Y_W + 1;
	localparam int NUM_W = 2 * CNT_W + 2 * YEAR_W + Y_W + 4;
	localparam int MPL_W = SDXX_W;
	localparam int DIV_CNT_W = $clog2(NUM_W + 1);
	localparam int LIM_W = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;

	typedef logic [YEAR_W-1:0]         year_t;
	typedef logic signed [Y_W-1:0]     anomaly_t;
	typedef logic [WLEN_W-1:0]         wlen_t;
	typedef logic [CNT_W-1:0]          count_t;
	typedef logic signed [SLOPE_W-1:0] slope_t;
	typedef logic signed [ICPT_W-1:0]  icpt_t;
	typedef logic [NUM_W-1:0]          num_t;

endpackage

FILE: hw/rtl/windowed_least_squares_fit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_least_squares_fit_top: windowed least-squares line fit
// Accumulates (year, anomaly) samples per window and, when a window closes,
// computes slope and intercept on one shared add/subtract unit.
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                    payload
// config    in         cfg_wr_en                    cfg_wr_data (window length)
// sample    in         sample_valid / sample_stall  sample_year, anomaly, last_sample
// fit       out        fit_valid / fit_stall        window_start_year, sample_count,
//                                                   slope, intercept, degenerate,
//                                                   final_window
//
// a sample that does not close its window passes through ST_PROD and ST_ACC before the next accept
// a closing sample then runs on the shared add/subtract unit: one
// multiplier bit per cycle for four products and a 70-step divide for the slope, then
// three products and another divide for the intercept; a degenerate window stops early
// reset sets the window length to 10 and clears the accumulators, no clearing pass
// sample_stall is high while busy; a fit waiting in the output register still lets samples in
// ----------------------------------------------------------------------------
module windowed_least_squares_fit_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  wlsf_pkg::wlen_t    cfg_wr_data,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  wlsf_pkg::year_t    sample_year,
	input  wlsf_pkg::anomaly_t anomaly,
	input  logic               last_sample,
	output logic               fit_valid,
	input  logic               fit_stall,
	output wlsf_pkg::year_t    window_start_year,
	output wlsf_pkg::count_t   sample_count,
	output wlsf_pkg::slope_t   slope,
	output wlsf_pkg::icpt_t    intercept,
	output logic               degenerate,
	output logic               final_window
);
	import wlsf_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_PROD, ST_ACC, ST_LOAD, ST_MUL,
		ST_TERM, ST_ABS, ST_DIV, ST_QUOT, ST_OUT
	} state_t;

	// products summed at window end, in order
	typedef enum logic [2:0] {
		TERM_NSXX,   // + n * sum_dxdx
		TERM_SXSX,   // - sum_dx * sum_dx   -> dxx
		TERM_NSXY,   // + n * sum_dxy
		TERM_SXSY,   // - sum_dx * sum_y    -> dxy
		TERM_SYSXX,  // + sum_y * sum_dxdx
		TERM_SXSXY,  // - sum_dx * sum_dxy
		TERM_FYDXY   // - first_year * dxy  -> intercept numerator
	} term_t;

	// saturate a quotient magnitude to the slope field and apply the sign
	function automatic slope_t sat_slope(input num_t q, input logic neg);
		logic ovf;
		ovf = |q[NUM_W-1:SLOPE_W-1];
		if (neg) begin
			sat_slope = ovf ? slope_t'({1'b1, {(SLOPE_W-1){1'b0}}})
			                : slope_t'(~q[SLOPE_W-1:0] + 1'b1);
		end else begin
			sat_slope = ovf ? slope_t'({1'b0, {(SLOPE_W-1){1'b1}}})
			                : slope_t'(q[SLOPE_W-1:0]);
		end
	endfunction

	// saturate a quotient magnitude to the intercept field and apply the sign
	function automatic icpt_t sat_icpt(input num_t q, input logic neg);
		logic ovf;
		ovf = |q[NUM_W-1:ICPT_W-1];
		if (neg) begin
			sat_icpt = ovf ? icpt_t'({1'b1, {(ICPT_W-1){1'b0}}})
			               : icpt_t'(~q[ICPT_W-1:0] + 1'b1);
		end else begin
			sat_icpt = ovf ? icpt_t'({1'b0, {(ICPT_W-1){1'b1}}})
			               : icpt_t'(q[ICPT_W-1:0]);
		end
	endfunction

	state_t                    state_q;
	term_t                     term_q;
	wlen_t                     wlen_q;

	// sample word and its products
	year_t                     dx_q;
	anomaly_t                  y_q;
	logic                      last_q;
	logic [PDXX_W-1:0]         pdxx_q;
	logic signed [PDXY_W-1:0]  pdxy_q;

	// window accumulators
	count_t                    count_q;
	year_t                     first_year_q;
	logic [SDX_W-1:0]          sdx_q;
	logic signed [SY_W-1:0]    sy_q;
	logic [SDXX_W-1:0]         sdxx_q;
	logic signed [SDXY_W-1:0]  sdxy_q;

	// shared unit operands and window-end values
	num_t                      acc_q;
	num_t                      mcand_q;
	logic [MPL_W-1:0]          mpl_q;
	logic [DIV_CNT_W-1:0]      cnt_q;
	logic                      sub_q;
	logic                      neg_q;
	logic                      div_icpt_q;
	logic                      degen_q;
	logic [DEN_W-1:0]          dxx_q;
	logic signed [DXY_W-1:0]   dxy_q;
	slope_t                    slope_q;
	icpt_t                     icpt_q;

	// output register
	logic                      fit_valid_q;
	year_t                     start_year_q;
	count_t                    out_count_q;
	slope_t                    out_slope_q;
	icpt_t                     out_icpt_q;
	logic                      out_degen_q;
	logic                      out_final_q;

	count_t                    cnt_inc;
	logic [LIM_W-1:0]          limit;
	logic                      win_close;
	num_t                      ld_mcand;
	logic [MPL_W-1:0]          ld_mpl;
	logic                      ld_sub;
	logic                      ld_clear;
	num_t                      rem_shift;
	num_t                      add_a;
	num_t                      add_b;
	logic                      add_sub;
	num_t                      add_sum;
	logic                      out_free;

	// window close decision
	assign cnt_inc   = count_q + 1'b1;
	assign limit     = (wlen_q == '0) ? LIM_W'(MAX_SAMPLES) : LIM_W'(wlen_q);
	assign win_close = (LIM_W'(cnt_inc) >= limit) || last_q;

	// operands of each window-end product
	always_comb begin
		ld_mcand = NUM_W'(sdxx_q);
		ld_mpl   = MPL_W'(count_q);
		ld_sub   = 1'b0;
		ld_clear = 1'b0;
		unique case (term_q)
			TERM_NSXX: begin
				ld_mcand = NUM_W'(sdxx_q);
				ld_mpl   = MPL_W'(count_q);
				ld_clear = 1'b1;
			end
			TERM_SXSX: begin
				ld_mcand = NUM_W'(sdx_q);
				ld_mpl   = MPL_W'(sdx_q);
				ld_sub   = 1'b1;
			end
			TERM_NSXY: begin
				ld_mcand = {{(NUM_W-SDXY_W){sdxy_q[SDXY_W-1]}}, sdxy_q};
				ld_mpl   = MPL_W'(count_q);
				ld_clear = 1'b1;
			end
			TERM_SXSY: begin
				ld_mcand = {{(NUM_W-SY_W){sy_q[SY_W-1]}}, sy_q};
				ld_mpl   = MPL_W'(sdx_q);
				ld_sub   = 1'b1;
			end
			TERM_SYSXX: begin
				ld_mcand = {{(NUM_W-SY_W){sy_q[SY_W-1]}}, sy_q};
				ld_mpl   = MPL_W'(sdxx_q);
				ld_clear = 1'b1;
			end
			TERM_SXSXY: begin
				ld_mcand = {{(NUM_W-SDXY_W){sdxy_q[SDXY_W-1]}}, sdxy_q};
				ld_mpl   = MPL_W'(sdx_q);
				ld_sub   = 1'b1;
			end
			TERM_FYDXY: begin
				ld_mcand = {{(NUM_W-DXY_W){dxy_q[DXY_W-1]}}, dxy_q};
				ld_mpl   = MPL_W'(first_year_q);
				ld_sub   = 1'b1;
			end
			default: begin
				ld_mcand = NUM_W'(sdxx_q);
			end
		endcase
	end

	// shared add/subtract unit
	assign rem_shift = {acc_q[NUM_W-2:0], mcand_q[NUM_W-1]};

	always_comb begin
		add_a   = acc_q;
		add_b   = mcand_q;
		add_sub = sub_q;
		unique case (state_q)
			ST_ABS: begin
				add_a   = '0;
				add_b   = acc_q;
				add_sub = acc_q[NUM_W-1];
			end
			ST_DIV: begin
				add_a   = rem_shift;
				add_b   = NUM_W'(dxx_q);
				add_sub = 1'b1;
			end
			default: begin
				add_a   = acc_q;
			end
		endcase
	end

	assign add_sum  = add_a + (add_b ^ {NUM_W{add_sub}}) + NUM_W'(add_sub);
	assign out_free = !fit_valid_q || !fit_stall;

	// sequencer, accumulators and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			term_q       <= TERM_NSXX;
			wlen_q       <= WLEN_W'(WLEN_RESET);
			count_q      <= '0;
			first_year_q <= '0;
			sdx_q        <= '0;
			sy_q         <= '0;
			sdxx_q       <= '0;
			sdxy_q       <= '0;
			fit_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				wlen_q <= cfg_wr_data;
			end
			// output register drains unless a new fit loads it this cycle
			if (fit_valid_q && !fit_stall && state_q != ST_OUT) begin
				fit_valid_q <= 1'b0;
			end

			unique case (state_q)
				// take a sample word and form its x offset
				ST_IDLE: begin
					if (sample_valid) begin
						if (count_q == '0) begin
							first_year_q <= sample_year;
							dx_q         <= '0;
						end else begin
							dx_q <= sample_year - first_year_q;
						end
						y_q     <= anomaly;
						last_q  <= last_sample;
						state_q <= ST_PROD;
					end
				end
				// per-sample products
				ST_PROD: begin
					pdxx_q  <= PDXX_W'(dx_q) * PDXX_W'(dx_q);
					pdxy_q  <= PDXY_W'($signed({1'b0, dx_q})) * PDXY_W'(y_q);
					state_q <= ST_ACC;
				end
				// running sums and window close check
				ST_ACC: begin
					count_q <= cnt_inc;
					sdx_q   <= sdx_q + SDX_W'(dx_q);
					sy_q    <= sy_q + {{(SY_W-Y_W){y_q[Y_W-1]}}, y_q};
					sdxx_q  <= sdxx_q + SDXX_W'(pdxx_q);
					sdxy_q  <= sdxy_q + {{(SDXY_W-PDXY_W){pdxy_q[PDXY_W-1]}}, pdxy_q};
					if (win_close) begin
						term_q  <= TERM_NSXX;
						state_q <= ST_LOAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				// load operands of the next product
				ST_LOAD: begin
					mcand_q <= ld_mcand;
					mpl_q   <= ld_mpl;
					sub_q   <= ld_sub;
					if (ld_clear) begin
						acc_q <= '0;
					end
					state_q <= ST_MUL;
				end
				// shift-add multiply, one multiplier bit per cycle
				ST_MUL: begin
					if (mpl_q == '0) begin
						state_q <= ST_TERM;
					end else begin
						if (mpl_q[0]) begin
							acc_q <= add_sum;
						end
						mcand_q <= mcand_q << 1;
						mpl_q   <= mpl_q >> 1;
					end
				end
				// product done: keep partial results, pick the next step
				ST_TERM: begin
					unique case (term_q)
						TERM_NSXX: begin
							term_q  <= TERM_SXSX;
							state_q <= ST_LOAD;
						end
						TERM_SXSX: begin
							dxx_q   <= acc_q[DEN_W-1:0];
							degen_q <= (count_q < CNT_W'(2)) || acc_q[NUM_W-1] ||
							           (acc_q == '0);
							term_q  <= TERM_NSXY;
							state_q <= ST_LOAD;
						end
						TERM_NSXY: begin
							term_q  <= TERM_SXSY;
							state_q <= ST_LOAD;
						end
						TERM_SXSY: begin
							dxy_q <= acc_q[DXY_W-1:0];
							if (degen_q) begin
								slope_q <= '0;
								icpt_q  <= '0;
								state_q <= ST_OUT;
							end else begin
								acc_q      <= acc_q << Y_FRAC;
								div_icpt_q <= 1'b0;
								state_q    <= ST_ABS;
							end
						end
						TERM_SYSXX: begin
							term_q  <= TERM_SXSXY;
							state_q <= ST_LOAD;
						end
						TERM_SXSXY: begin
							term_q  <= TERM_FYDXY;
							state_q <= ST_LOAD;
						end
						TERM_FYDXY: begin
							div_icpt_q <= 1'b1;
							state_q    <= ST_ABS;
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
				// numerator magnitude into the dividend register
				ST_ABS: begin
					neg_q   <= acc_q[NUM_W-1];
					mcand_q <= add_sum;
					acc_q   <= '0;
					cnt_q   <= DIV_CNT_W'(NUM_W);
					state_q <= ST_DIV;
				end
				// restoring divide, one quotient bit per cycle
				ST_DIV: begin
					if (!add_sum[NUM_W-1]) begin
						acc_q <= add_sum;
					end else begin
						acc_q <= rem_shift;
					end
					mcand_q <= {mcand_q[NUM_W-2:0], ~add_sum[NUM_W-1]};
					cnt_q   <= cnt_q - 1'b1;
					if (cnt_q == DIV_CNT_W'(1)) begin
						state_q <= ST_QUOT;
					end
				end
				// saturate the quotient
				ST_QUOT: begin
					if (div_icpt_q) begin
						icpt_q  <= sat_icpt(mcand_q, neg_q);
						state_q <= ST_OUT;
					end else begin
						slope_q <= sat_slope(mcand_q, neg_q);
						term_q  <= TERM_SYSXX;
						state_q <= ST_LOAD;
					end
				end
				// hand the result to the output register and start a new window
				ST_OUT: begin
					if (out_free) begin
						fit_valid_q  <= 1'b1;
						start_year_q <= first_year_q;
						out_count_q  <= count_q;
						out_slope_q  <= slope_q;
						out_icpt_q   <= icpt_q;
						out_degen_q  <= degen_q;
						out_final_q  <= last_q;
						count_q      <= '0;
						first_year_q <= '0;
						sdx_q        <= '0;
						sy_q         <= '0;
						sdxx_q       <= '0;
						sdxy_q       <= '0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign sample_stall      = (state_q != ST_IDLE);
	assign fit_valid         = fit_valid_q;
	assign window_start_year = start_year_q;
	assign sample_count      = out_count_q;
	assign slope             = out_slope_q;
	assign intercept         = out_icpt_q;
	assign degenerate        = out_degen_q;
	assign final_window      = out_final_q;

	// a degenerate window reports a zero fit
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		fit_valid && degenerate |-> slope == '0 && intercept == '0)
		else $error("degenerate window with nonzero fit");

	// a fitted window holds at least one sample, at least two unless degenerate, and no more than the limit
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		fit_valid |-> sample_count != '0 && sample_count <= CNT_W'(MAX_SAMPLES) &&
		(degenerate || sample_count >= CNT_W'(2)))
		else $error("window sample count out of range");

	// divider step counter never runs out while dividing
	a_div_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cnt_q != '0)
		else $error("divider counter underflow");

	// window accumulator stays within the sample limit
	a_win_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_SAMPLES))
		else $error("window count beyond limit");

endmodule

FILE: bench/wlsf_fit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlsf_fit_checker: scoreboard for the windowed least-squares fit
// Watches the config, sample and fit channels, keeps its own window
// accumulators and register copy, predicts each closed window's fit with
// wide exact arithmetic, and compares every fit word field by field.
// ----------------------------------------------------------------------------
module wlsf_fit_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  wlsf_pkg::wlen_t    cfg_wr_data,
	input  logic               sample_valid,
	input  logic               sample_stall,
	input  wlsf_pkg::year_t    sample_year,
	input  wlsf_pkg::anomaly_t anomaly,
	input  logic               last_sample,
	input  logic               fit_valid,
	input  logic               fit_stall,
	input  wlsf_pkg::year_t    window_start_year,
	input  wlsf_pkg::count_t   sample_count,
	input  wlsf_pkg::slope_t   slope,
	input  wlsf_pkg::icpt_t    intercept,
	input  logic               degenerate,
	input  logic               final_window,
	output int                 mismatches,
	output int                 fits_due
);
	import wlsf_pkg::*;

	typedef logic signed [127:0] wide_t;
	typedef logic signed [63:0]  field_t;

	typedef struct packed {
		year_t  start_year;
		count_t n_samples;
		slope_t slope_q;
		icpt_t  icpt_q;
		logic   degen;
		logic   closed_by_last;
	} fit_word_t;

	// fits predicted but not yet seen on the output
	fit_word_t fit_queue[$];
	fit_word_t want;
	int        fits_seen = 0;

	// window state and register copy
	wlen_t  win_len = wlen_t'(WLEN_RESET);
	int     n_acc = 0;
	year_t  first_yr = '0;
	longint s_dx = 0;
	longint s_y = 0;
	longint s_dxx = 0;
	longint s_dxy = 0;

	initial begin
		mismatches = 0;
		fits_due = 0;
	end

	// saturate to a signed field of the given width
	function automatic wide_t clamp_to(wide_t v, int bits);
		wide_t hi_lim, lo_lim;
		hi_lim = (wide_t'(1) <<< (bits - 1)) - 1;
		lo_lim = -(wide_t'(1) <<< (bits - 1));
		if (v > hi_lim)
			return hi_lim;
		if (v < lo_lim)
			return lo_lim;
		return v;
	endfunction

	// least-squares fit of the window held in the accumulators
	function automatic fit_word_t fit_line(logic closing_last);
		wide_t     wn, wdx, wy, wdxx, wdxy, den, dxy, num;
		fit_word_t w;
		w.start_year = first_yr;
		w.n_samples = count_t'(n_acc);
		w.slope_q = '0;
		w.icpt_q = '0;
		w.degen = 1'b0;
		w.closed_by_last = closing_last;
		wn = n_acc;
		wdx = s_dx;
		wy = s_y;
		wdxx = s_dxx;
		wdxy = s_dxy;
		den = wn * wdxx - wdx * wdx;
		dxy = wn * wdxy - wdx * wy;
		if (n_acc < 2 || den <= 0) begin
			w.degen = 1'b1;
		end else begin
			w.slope_q = slope_t'(clamp_to((dxy <<< Y_FRAC) / den, SLOPE_W));
			num = wy * wdxx - wdx * wdxy - dxy * wide_t'(first_yr);
			w.icpt_q = icpt_t'(clamp_to(num / den, ICPT_W));
		end
		return w;
	endfunction

	task automatic clear_window();
		n_acc = 0;
		first_yr = '0;
		s_dx = 0;
		s_y = 0;
		s_dxx = 0;
		s_dxy = 0;
	endtask

	// add one accepted sample word, close the window when due
	task automatic absorb_sample();
		year_t  dx12;
		longint dx, yv;
		int     lim;
		if (n_acc == 0)
			first_yr = sample_year;
		dx12 = sample_year - first_yr;
		dx = dx12;
		yv = anomaly;
		n_acc++;
		s_dx += dx;
		s_y += yv;
		s_dxx += dx * dx;
		s_dxy += dx * yv;
		lim = (win_len == 0) ? MAX_SAMPLES : int'(win_len);
		if (n_acc >= lim || last_sample) begin
			fit_queue.insert(fit_queue.size(), fit_line(last_sample));
			clear_window();
		end
	endtask

	task automatic check_field(string field, field_t exp_val, field_t got_val);
		if (got_val !== exp_val) begin
			mismatches++;
			if (mismatches <= 10)
				$display("fit %0d: %s expected %0d, got %0d",
					fits_seen, field, exp_val, got_val);
		end
	endtask

	// compare outgoing fit words, then follow config and sample words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len = wlen_t'(WLEN_RESET);
			clear_window();
			fit_queue.delete();
			fits_due = 0;
		end else begin
			if (fit_valid && !fit_stall) begin
				if (fit_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("fit %0d: no window closed, got start %0d count %0d",
							fits_seen, window_start_year, sample_count);
				end else begin
					want = fit_queue.pop_front();
					check_field("window_start_year", want.start_year, window_start_year);
					check_field("sample_count", want.n_samples, sample_count);
					check_field("slope", want.slope_q, slope);
					check_field("intercept", want.icpt_q, intercept);
					check_field("degenerate", want.degen, degenerate);
					check_field("final_window", want.closed_by_last, final_window);
				end
				fits_seen++;
			end
			if (cfg_wr_en)
				win_len = cfg_wr_data;
			if (sample_valid && !sample_stall)
				absorb_sample();
			fits_due = fit_queue.size();
		end
	end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for the windowed least-squares fit
// Drives directed corner windows, then random sample streams under several
// window lengths with random gaps and output stalls.
// The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
	import wlsf_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 20;
	localparam int DRAIN_CYCLES = 400;
	localparam int PHASES = 12;

	typedef enum {SEG_TREND, SEG_RANDOM_Y, SEG_SCRAMBLED, SEG_FLAT_YEAR} seg_kind_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     cfg_wr_en = 1'b0;
	wlen_t    cfg_wr_data = '0;
	logic     sample_valid = 1'b0;
	logic     sample_stall;
	year_t    sample_year = '0;
	anomaly_t anomaly = '0;
	logic     last_sample = 1'b0;
	logic     fit_valid;
	logic     fit_stall = 1'b0;
	year_t    window_start_year;
	count_t   sample_count;
	slope_t   slope;
	icpt_t    intercept;
	logic     degenerate;
	logic     final_window;

	int fit_errors;
	int fits_due;

	// sender pacing and sample series state
	logic      snd_quiet = 1'b0;
	seg_kind_t seg_kind = SEG_TREND;
	int        seg_left = 0;
	int        seg_step = 1;
	int        seg_base = 0;
	int        seg_trend = 0;
	int        seg_noise = 0;
	int        seg_k = 0;
	year_t     seg_year = '0;

	// receiver pacing and watchdog
	int stall_left = 0;
	int rx_roll;
	int idle_cycles = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	windowed_least_squares_fit_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample_year(sample_year),
		.anomaly(anomaly),
		.last_sample(last_sample),
		.fit_valid(fit_valid),
		.fit_stall(fit_stall),
		.window_start_year(window_start_year),
		.sample_count(sample_count),
		.slope(slope),
		.intercept(intercept),
		.degenerate(degenerate),
		.final_window(final_window)
	);

	wlsf_fit_checker fit_chk (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample_year(sample_year),
		.anomaly(anomaly),
		.last_sample(last_sample),
		.fit_valid(fit_valid),
		.fit_stall(fit_stall),
		.window_start_year(window_start_year),
		.sample_count(sample_count),
		.slope(slope),
		.intercept(intercept),
		.degenerate(degenerate),
		.final_window(final_window),
		.mismatches(fit_errors),
		.fits_due(fits_due)
	);

	// output stall pattern: short bursts, rare long holds, stretches with none
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else begin
			rx_roll = $urandom_range(0, 99);
			if (rx_roll < 4) begin
				fit_stall <= 1'b0;
				stall_left <= $urandom_range(200, 600);
			end else if (rx_roll < 55) begin
				fit_stall <= 1'b0;
				stall_left <= $urandom_range(0, 6);
			end else if (rx_roll < 90) begin
				fit_stall <= 1'b1;
				stall_left <= $urandom_range(0, 3);
			end else if (rx_roll < 98) begin
				fit_stall <= 1'b1;
				stall_left <= $urandom_range(10, 60);
			end else begin
				fit_stall <= 1'b1;
				stall_left <= $urandom_range(100, 300);
			end
		end
	end

	// give up when no word moves on either channel for too long
	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (fit_valid && !fit_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", idle_cycles);
			$display("FAILED: results differ");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic int pick_gap();
		int r;
		if (snd_quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// present one sample word and hold it until taken; returns at a falling edge
	task automatic send_sample(year_t yr, anomaly_t a, logic l);
		int gap;
		gap = pick_gap();
		if ($urandom_range(0, 99) == 0)
			snd_quiet = !snd_quiet;
		if (gap > 0) begin
			sample_valid = 1'b0;
			sample_year = year_t'($urandom);
			anomaly = anomaly_t'($urandom);
			last_sample = 1'($urandom_range(0, 1));
			repeat (gap) @(negedge clk);
		end
		sample_valid = 1'b1;
		sample_year = yr;
		anomaly = a;
		last_sample = l;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// wait until every predicted fit is out and the block has gone quiet
	task automatic settle(int cycles);
		sample_valid = 1'b0;
		wait (fits_due == 0);
		@(negedge clk);
		repeat (cycles) @(negedge clk);
	endtask

	task automatic set_window_length(wlen_t v);
		cfg_wr_en = 1'b1;
		cfg_wr_data = v;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// next sample of a series: mostly ascending years with trend or random y
	task automatic next_sample(output year_t yr, output anomaly_t a, output logic l);
		int v, r;
		if (seg_left == 0) begin
			r = $urandom_range(0, 99);
			seg_kind = (r < 60) ? SEG_TREND : (r < 85) ? SEG_RANDOM_Y :
				(r < 95) ? SEG_SCRAMBLED : SEG_FLAT_YEAR;
			seg_left = $urandom_range(5, 60);
			seg_year = year_t'($urandom);
			seg_step = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 5) : 1;
			seg_base = int'($urandom_range(0, 60000)) - 30000;
			seg_trend = int'($urandom_range(0, 4000)) - 2000;
			seg_noise = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 3000);
			seg_k = 0;
		end
		seg_left--;
		case (seg_kind)
			SEG_TREND: begin
				seg_year += year_t'(seg_step);
				v = seg_base + seg_trend * seg_k
					+ int'($urandom_range(0, 2 * seg_noise)) - seg_noise;
				if (v > 32767)
					v = 32767;
				else if (v < -32768)
					v = -32768;
				a = anomaly_t'(v);
			end
			SEG_RANDOM_Y: begin
				seg_year += year_t'(seg_step);
				a = anomaly_t'($urandom);
			end
			SEG_SCRAMBLED: begin
				seg_year = year_t'($urandom);
				a = anomaly_t'($urandom);
			end
			default: begin
				a = anomaly_t'($urandom);
			end
		endcase
		seg_k++;
		yr = seg_year;
		l = ($urandom_range(0, 39) == 0);
	endtask

	initial begin
		year_t    yr;
		anomaly_t a;
		logic     l;
		int       n;
		wlen_t    phase_len[PHASES];

		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// single sample closed by last_sample: degenerate
		send_sample(12'd0, 16'sd0, 1'b1);
		// all samples in one year: zero x variance
		send_sample(12'd4095, anomaly_t'(100), 1'b0);
		send_sample(12'd4095, anomaly_t'(-100), 1'b0);
		send_sample(12'd4095, 16'sh7FFF, 1'b1);
		// full window at the reset length, years wrap past the top, extreme y
		for (int i = 0; i < 10; i++)
			send_sample(year_t'(4090 + i), (i % 2) ? 16'sh7FFF : 16'sh8000, 1'b0);
		// years going backwards
		send_sample(12'd100, anomaly_t'(1234), 1'b0);
		send_sample(12'd50, anomaly_t'(-4321), 1'b1);
		// steepest slope at the top of the year range
		send_sample(12'd4094, 16'sh8000, 1'b0);
		send_sample(12'd4095, 16'sh7FFF, 1'b1);
		settle(SETTLE_CYCLES);

		// one window of three, one sample left open
		set_window_length(8'd3);
		for (int i = 0; i < 4; i++)
			send_sample(year_t'(2000 + i), anomaly_t'($urandom), 1'b0);
		settle(SETTLE_CYCLES);
		// length drops to the open count: closes on the next word
		set_window_length(8'd1);
		for (int i = 0; i < 3; i++)
			send_sample(year_t'(3000 + i), anomaly_t'($urandom), 1'b0);

		// random streams under a spread of window lengths
		phase_len = '{8'd2, 8'd255, 8'd0, 8'd1, 8'd3, 8'd128, 8'd0, 8'd0, 8'd17, 8'd0,
			8'd5, 8'd255};
		phase_len[6] = wlen_t'($urandom_range(4, 254));
		phase_len[9] = wlen_t'($urandom_range(0, 255));
		for (int p = 0; p < PHASES; p++) begin
			settle(SETTLE_CYCLES);
			set_window_length(phase_len[p]);
			n = (phase_len[p] > 100) ? 260 : 120;
			repeat (n) begin
				next_sample(yr, a, l);
				send_sample(yr, a, l);
			end
		end

		settle(DRAIN_CYCLES);
		if (fit_errors == 0 && fits_due == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/wlsf_pkg.sv
hw/rtl/windowed_least_squares_fit_top.sv
bench/wlsf_fit_checker.sv
bench/tb.sv
